/* rtl/dbpf_pkg.sv */
// ----------------------------------------------------------------------------
// dbpf_pkg
// Shared types and constants of the distance band pair finder.
// ----------------------------------------------------------------------------
`default_nettype none

package dbpf_pkg;

  // Default store capacity
  localparam int MAX_POINTS_DEF = 64;

  // Fixed field widths
  localparam int IDX_W     = 6;
  localparam int COORD_W   = 16;
  localparam int DIST_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 2'd1;

  // Squared bounds after reset: 0 and 65535^2
  localparam logic [2*DIST_W-1:0] LO2_RESET = 32'h0000_0000;
  localparam logic [2*DIST_W-1:0] HI2_RESET = 32'hFFFE_0001;

  // Queue depths
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 8;

  // Classified point handed from front end to back end
  typedef struct packed {
    logic                      full;
    logic [IDX_W-1:0]          index;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
    logic             status;
    logic             last;
  } res_t;

  // Back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN
  } back_state_t;

endpackage

`default_nettype wire

/* rtl/distance_band_pair_finder.sv */
// Path: a point passes the command queue; each earlier point is then read from the
//   store and goes through abs-diff, square and sum registers to the band test.
// Throughput: the back end takes a new point only when idle and sweeps one stored
//   point per cycle while the result queue has room; a drop just queues a status.
// Reset (rst, synchronous) clears the fill count and queues and restores the bounds;
//   the point store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// distance_band_pair_finder
// Emits drop statuses and index pairs of 3D points within a configured distance band.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_band_pair_finder
  import dbpf_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // point channel
  input  wire logic                      pt_valid,
  output logic                           pt_stall,
  input  wire logic                      restart,
  input  wire logic signed [COORD_W-1:0] x_coord,
  input  wire logic signed [COORD_W-1:0] y_coord,
  input  wire logic signed [COORD_W-1:0] z_coord,
  // result channel
  output logic                           res_valid,
  input  wire logic                      res_stall,
  output logic [IDX_W-1:0]               first_index,
  output logic [IDX_W-1:0]               second_index,
  output logic                           status,
  output logic                           last,
  // configuration write channel
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [DIST_W-1:0]         cfg_data
);

  logic q_in_valid;
  logic q_in_ready;
  cmd_t q_in_data;
  logic q_out_valid;
  logic q_out_ready;
  cmd_t q_out_data;
  res_t res_data;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  dbpf_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .pt_valid (pt_valid),
    .pt_stall (pt_stall),
    .restart  (restart),
    .x_coord  (x_coord),
    .y_coord  (y_coord),
    .z_coord  (z_coord),
    .q_valid  (q_in_valid),
    .q_ready  (q_in_ready),
    .q_data   (q_in_data)
  );

  dbpf_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_data  (q_in_data),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_data   (q_out_data)
  );

  dbpf_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (q_out_valid),
    .cmd_ready (q_out_ready),
    .cmd_data  (q_out_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  assign first_index  = res_data.first_index;
  assign second_index = res_data.second_index;
  assign status       = res_data.status;
  assign last         = res_data.last;

endmodule

`default_nettype wire

/* rtl/dbpf_cmd_queue.sv */
// ----------------------------------------------------------------------------
// dbpf_cmd_queue
// Short queue of classified points between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dbpf_cmd_queue
  import dbpf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  cmd_t      push_data,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_data
);

  localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CW = $clog2(CMD_DEPTH + 1);

  cmd_t          entries [CMD_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(CMD_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(CMD_DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(CMD_DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/dbpf_front.sv */
// ----------------------------------------------------------------------------
// dbpf_front
// Accepts points, tracks the fill count and classifies each point as stored
// at a given index or dropped because the store is full.
// ----------------------------------------------------------------------------
`default_nettype none

module dbpf_front
  import dbpf_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      pt_valid,
  output logic                           pt_stall,
  input  wire logic                      restart,
  input  wire logic signed [COORD_W-1:0] x_coord,
  input  wire logic signed [COORD_W-1:0] y_coord,
  input  wire logic signed [COORD_W-1:0] z_coord,
  output logic                           q_valid,
  input  wire logic                      q_ready,
  output cmd_t                           q_data
);

  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_eff;
  logic          full;
  logic          accept;

  // classification
  assign count_eff = restart ? '0 : count;
  assign full      = (count_eff == CW'(MAX_POINTS));
  assign accept    = pt_valid && !pt_stall;

  assign pt_stall      = !q_ready;
  assign q_valid       = pt_valid;
  assign q_data.full   = full;
  assign q_data.index  = IDX_W'(count_eff);
  assign q_data.x      = x_coord;
  assign q_data.y      = y_coord;
  assign q_data.z      = z_coord;

  // fill count; a dropped point leaves it as is
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= full ? count_eff : count_eff + CW'(1);
    end
  end

endmodule

`default_nettype wire

/* rtl/dbpf_back.sv */
// ----------------------------------------------------------------------------
// dbpf_back
// Stores each point not dropped, sweeps the earlier points through a pipelined
// distance unit, and queues the pair and status results.
// ----------------------------------------------------------------------------
`default_nettype none

module dbpf_back
  import dbpf_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIST_W-1:0]    cfg_data,
  // command queue
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  cmd_t                      cmd_data,
  // results
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output res_t                      res_data
);

  localparam int IW  = $clog2(MAX_POINTS);
  localparam int OPW = $clog2(OUT_DEPTH);
  localparam int OCW = $clog2(OUT_DEPTH + 1);
  localparam int RW  = OCW + 1;
  localparam int SQW = 2 * COORD_W;
  localparam int D2W = SQW + 2;

  function automatic logic [COORD_W-1:0] abs_diff(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] d;
    d = COORD_W'(0) + ({a[COORD_W-1], a} - {b[COORD_W-1], b});
    return d[COORD_W] ? COORD_W'(-d) : COORD_W'(d);
  endfunction

  // squared bounds
  logic [SQW-1:0] lo2;
  logic [SQW-1:0] hi2;

  // point store
  logic [3*COORD_W-1:0] mem [MAX_POINTS];
  logic [3*COORD_W-1:0] rd_data;

  // sequencer
  back_state_t               state;
  back_state_t               state_next;
  logic signed [COORD_W-1:0] cur_x;
  logic signed [COORD_W-1:0] cur_y;
  logic signed [COORD_W-1:0] cur_z;
  logic [IDX_W-1:0]          cur_k;
  logic [IW-1:0]             rd_idx;
  logic                      start;
  logic                      issue;
  logic                      last_issue;
  logic                      room;

  // distance pipeline
  logic           v1, v2, v3, v4;
  logic [IW-1:0]  idx1, idx2, idx3, idx4;
  logic [COORD_W-1:0] ad_x, ad_y, ad_z;
  logic [SQW-1:0] sq_x, sq_y, sq_z;
  logic [D2W-1:0] d2;
  logic           match;
  res_t           new_res;

  // held match, released once the next one or the end is known
  logic pend_valid;
  res_t pend;
  logic pend_clr;

  // result queue
  res_t           ofifo [OUT_DEPTH];
  logic [OPW-1:0] wptr;
  logic [OPW-1:0] rptr;
  logic [OCW-1:0] ocnt;
  logic           push;
  res_t           push_data;
  logic           pop;

  // configuration: bounds squared at write time
  always_ff @(posedge clk) begin
    if (rst) begin
      lo2 <= LO2_RESET;
      hi2 <= HI2_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_DISTANCE: lo2 <= cfg_data * cfg_data;
        CFG_MAX_DISTANCE: hi2 <= cfg_data * cfg_data;
        default: ;
      endcase
    end
  end

  // issue credit: every queued, held or in-flight result has a slot
  assign room = (RW'(ocnt) + RW'(pend_valid) + RW'(v1) + RW'(v2) + RW'(v3) + RW'(v4))
                < RW'(OUT_DEPTH);
  assign issue      = (state == BK_RUN) && room;
  assign last_issue = (IDX_W'(rd_idx) == cur_k - IDX_W'(1));

  // band test on the summed squares
  assign match = v4 && (d2 >= D2W'(lo2)) && (d2 <= D2W'(hi2));
  assign new_res.first_index  = IDX_W'(idx4);
  assign new_res.second_index = cur_k;
  assign new_res.status       = 1'b0;
  assign new_res.last         = 1'b0;

  // sequencer next state and controls
  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    start      = 1'b0;
    pend_clr   = 1'b0;
    push       = 1'b0;
    push_data  = pend;
    case (state)
      BK_IDLE: begin
        if (cmd_valid && (ocnt != OCW'(OUT_DEPTH))) begin
          cmd_ready = 1'b1;
          if (cmd_data.full) begin
            push                   = 1'b1;
            push_data.first_index  = '0;
            push_data.second_index = '0;
            push_data.status       = 1'b1;
            push_data.last         = 1'b1;
          end else begin
            start = 1'b1;
            if (cmd_data.index != '0) begin
              state_next = BK_RUN;
            end
          end
        end
      end
      BK_RUN: begin
        if (issue && last_issue) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (!(v1 || v2 || v3 || v4)) begin
          if (pend_valid) begin
            push           = 1'b1;
            push_data.last = 1'b1;
            pend_clr       = 1'b1;
          end
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
    // a new match releases the held one, not the last of its point
    if (match && pend_valid) begin
      push      = 1'b1;
      push_data = pend;
    end
  end

  // state and pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      if (match) begin
        pend_valid <= 1'b1;
      end else if (pend_clr) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // current point and sweep index
  always_ff @(posedge clk) begin
    if (start) begin
      cur_x  <= cmd_data.x;
      cur_y  <= cmd_data.y;
      cur_z  <= cmd_data.z;
      cur_k  <= cmd_data.index;
      rd_idx <= '0;
    end else if (issue) begin
      rd_idx <= rd_idx + IW'(1);
    end
    if (match) begin
      pend <= new_res;
    end
  end

  // point store: write on start, registered read on issue
  always_ff @(posedge clk) begin
    if (start) begin
      mem[cmd_data.index[IW-1:0]] <= {cmd_data.x, cmd_data.y, cmd_data.z};
    end
    if (issue) begin
      rd_data <= mem[rd_idx];
    end
  end

  // distance pipeline: abs diffs, squares, sum
  always_ff @(posedge clk) begin
    idx1 <= rd_idx;
    idx2 <= idx1;
    idx3 <= idx2;
    idx4 <= idx3;
    ad_x <= abs_diff(rd_data[3*COORD_W-1:2*COORD_W], cur_x);
    ad_y <= abs_diff(rd_data[2*COORD_W-1:COORD_W], cur_y);
    ad_z <= abs_diff(rd_data[COORD_W-1:0], cur_z);
    sq_x <= ad_x * ad_x;
    sq_y <= ad_y * ad_y;
    sq_z <= ad_z * ad_z;
    d2   <= D2W'(sq_x) + D2W'(sq_y) + D2W'(sq_z);
  end

  // result queue
  assign res_valid = (ocnt != '0);
  assign res_data  = ofifo[rptr];
  assign pop       = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      ocnt <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == OPW'(OUT_DEPTH - 1)) ? '0 : wptr + OPW'(1);
      end
      if (pop) begin
        rptr <= (rptr == OPW'(OUT_DEPTH - 1)) ? '0 : rptr + OPW'(1);
      end
      case ({push, pop})
        2'b10:   ocnt <= ocnt + OCW'(1);
        2'b01:   ocnt <= ocnt - OCW'(1);
        default: ocnt <= ocnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ofifo[wptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/dbpf_checker.sv */
// ----------------------------------------------------------------------------
// dbpf_checker
// Port-level checks of the pair finder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dbpf_checker
  import dbpf_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      res_valid,
  input wire logic                      res_stall,
  input wire logic [IDX_W-1:0]          first_index,
  input wire logic [IDX_W-1:0]          second_index,
  input wire logic                      status,
  input wire logic                      last
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(first_index)
      && $stable(second_index) && $stable(status) && $stable(last))
    else $error("result changed while stalled");

  // a drop status is a lone, final transaction with zero indexes
  a_drop_form: assert property (@(posedge clk) disable iff (rst)
    res_valid && status |-> last && (first_index == '0) && (second_index == '0))
    else $error("malformed drop status");

  // a pair names the earlier point first
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    res_valid && !status |-> first_index < second_index)
    else $error("pair indexes out of order");

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result pending after reset");

endmodule

bind distance_band_pair_finder dbpf_checker u_chk (.*);

`default_nettype wire
